// ===== design/ktt_pkg.sv =====
`timescale 1ns / 1ps
package ktt_pkg;
	localparam int Timers   = 64;
	localparam int KeyBytes = 16;
	localparam int IdxW     = $clog2(Timers);
	localparam int CntW     = $clog2(Timers + 1);
	localparam int TimeW    = 40;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_ADD  = 2'd1,
		FUNC_DEL  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_DUP      = 3'd1,
		KIND_BADLEN   = 3'd2,
		KIND_FULL     = 3'd3,
		KIND_DELETED  = 3'd4,
		KIND_NOTFOUND = 3'd5,
		KIND_EXPIRED  = 3'd6,
		KIND_TICKNONE = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_FETCH,
		ST_WAIT,
		ST_OUT
	} state_t;

	// One table row: key, length, port, value, deadline, order stamp.
	typedef struct packed {
		logic [127:0] key;
		logic [4:0]   len;
		logic [15:0]  port;
		logic [31:0]  value;
		logic [TimeW-1:0] deadline;
		logic [31:0]  order;
	} entry_t;

	function automatic logic [127:0] key_mask(input logic [4:0] len);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < KeyBytes; b++)
			if (b < int'(len)) m[b*8 +: 8] = 8'hff;
		return m;
	endfunction
endpackage

// ===== design/keyed_timeout_table_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Signals
// in       sink       in_valid/in_ready, func, key_*, key_len, port_tag, user_value, delay_ms
// out      source     out_valid/out_ready, kind, out_key_*, out_key_len, out_port, out_value, last
// An item sweeps the entry memory one row a cycle; a pass consists of scan, last read and
// decision. Add and delete take one pass and then stage their result in the output state.
// A tick takes one pass per expired entry plus a fetch through the fetch, wait and output
// states to stage it, then one final pass.
// The entry memory is read in the scan and the fetch; the valid bits are flip-flops cleared by reset.
// A released result must transfer before the next one is staged; input waits for idle.
module keyed_timeout_table_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   func,
	input  logic [63:0]  key_low,
	input  logic [63:0]  key_high,
	input  logic [4:0]   key_len,
	input  logic [15:0]  port_tag,
	input  logic [31:0]  user_value,
	input  logic [30:0]  delay_ms,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   kind,
	output logic [63:0]  out_key_low,
	output logic [63:0]  out_key_high,
	output logic [4:0]   out_key_len,
	output logic [15:0]  out_port,
	output logic [31:0]  out_value,
	output logic         last
);
	localparam int IW = ktt_pkg::IdxW;
	localparam int TW = ktt_pkg::TimeW;
	localparam logic [TW-1:0] Half = {1'b1, {(TW-1){1'b0}}};

	ktt_pkg::entry_t mem [ktt_pkg::Timers];
	ktt_pkg::entry_t rd_q;
	logic [ktt_pkg::Timers-1:0] valid_q;

	ktt_pkg::state_t state_q, state_d;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   rd_idx_q;
	logic            rd_ok_q;

	logic [1:0]   func_q;
	logic [127:0] key_q;
	logic [4:0]   len_q;
	logic         len_ok_q;
	logic [15:0]  port_q;
	logic [31:0]  value_q;
	logic [30:0]  delay_q;

	logic [TW-1:0] now_q;
	logic [31:0]   cnt_q;

	logic          hit_q, best_ok_q, free_ok_q, emitted_q;
	logic [IW-1:0] hit_idx_q, best_idx_q, free_idx_q;
	logic [TW-1:0] best_age_q;
	logic [31:0]   best_ord_q;

	logic [TW-1:0] age;
	logic          due, better, match;
	logic          rd_en, scan_step, out_fire, in_fire, out_load;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == ktt_pkg::ST_IDLE) && !out_valid;
	assign out_load = (state_q == ktt_pkg::ST_OUT) && !out_valid;

	always_comb begin
		age    = now_q - rd_q.deadline;
		due    = rd_ok_q && (age < Half);
		better = !best_ok_q || (age > best_age_q) ||
			((age == best_age_q) && ((best_ord_q - rd_q.order) < 32'h8000_0000));
		match  = rd_ok_q && len_ok_q && (rd_q.len == len_q) && (rd_q.key == key_q);
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		scan_step = 1'b0;
		unique case (state_q)
			ktt_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (ktt_pkg::func_t'(func) == ktt_pkg::FUNC_NONE) state_d = ktt_pkg::ST_IDLE;
					else state_d = ktt_pkg::ST_SCAN;
				end
			end
			ktt_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				scan_step = 1'b1;
				if (idx_q == IW'(ktt_pkg::Timers - 1)) state_d = ktt_pkg::ST_LAST;
			end
			ktt_pkg::ST_LAST: begin
				scan_step = 1'b1;
				state_d = ktt_pkg::ST_DECIDE;
			end
			ktt_pkg::ST_DECIDE: begin
				if (!out_valid) begin
					if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && best_ok_q)
						state_d = ktt_pkg::ST_FETCH;
					else if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && emitted_q)
						state_d = ktt_pkg::ST_IDLE;
					else
						state_d = ktt_pkg::ST_OUT;
				end
			end
			ktt_pkg::ST_FETCH: begin
				rd_en = 1'b1;
				state_d = ktt_pkg::ST_WAIT;
			end
			ktt_pkg::ST_WAIT: state_d = ktt_pkg::ST_OUT;
			ktt_pkg::ST_OUT: begin
				if (!out_valid) begin
					if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && best_ok_q)
						state_d = ktt_pkg::ST_SCAN;
					else
						state_d = ktt_pkg::ST_IDLE;
				end
			end
			default: state_d = ktt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ktt_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Entry memory: one write port, one registered read port.
	logic          wr_en;
	logic [IW-1:0] rd_addr;
	ktt_pkg::entry_t wr_data;
	assign rd_addr = (state_q == ktt_pkg::ST_FETCH) ? best_idx_q : idx_q;
	assign wr_en = (state_q == ktt_pkg::ST_DECIDE) && !out_valid &&
		ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_ADD && len_ok_q && !hit_q && free_ok_q;
	always_comb begin
		wr_data.key      = key_q;
		wr_data.len      = len_q;
		wr_data.port     = port_q;
		wr_data.value    = value_q;
		wr_data.deadline = now_q + {{(TW-31){1'b0}}, delay_q};
		wr_data.order    = cnt_q;
	end
	always_ff @(posedge clk) begin
		if (wr_en) mem[free_idx_q] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			idx_q      <= '0;
			rd_idx_q   <= '0;
			rd_ok_q    <= 1'b0;
			now_q      <= '0;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			best_ok_q  <= 1'b0;
			free_ok_q  <= 1'b0;
			emitted_q  <= 1'b0;
			hit_idx_q  <= '0;
			best_idx_q <= '0;
			free_idx_q <= '0;
			best_age_q <= '0;
			best_ord_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			if (in_fire) begin
				idx_q     <= '0;
				rd_ok_q   <= 1'b0;
				hit_q     <= 1'b0;
				best_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
				emitted_q <= 1'b0;
			end
			if (scan_step) begin
				if (state_q == ktt_pkg::ST_SCAN) idx_q <= idx_q + 1'b1;
				rd_idx_q <= idx_q;
				rd_ok_q  <= (state_q == ktt_pkg::ST_SCAN) && valid_q[idx_q];
				if (state_q == ktt_pkg::ST_SCAN && !valid_q[idx_q] && !free_ok_q) begin
					free_ok_q  <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (match) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_q;
				end
				if (due && better) begin
					best_ok_q  <= 1'b1;
					best_idx_q <= rd_idx_q;
					best_age_q <= age;
					best_ord_q <= rd_q.order;
				end
			end
			if (state_q == ktt_pkg::ST_DECIDE && !out_valid) begin
				unique case (ktt_pkg::func_t'(func_q))
					ktt_pkg::FUNC_TICK: begin
						if (best_ok_q) begin
							valid_q[best_idx_q] <= 1'b0;
							// Another expiry follows, so the staged one is not the last.
							if (emitted_q) out_valid <= 1'b1;
						end else if (emitted_q) begin
							out_valid <= 1'b1;
							now_q <= now_q + 1'b1;
						end else now_q <= now_q + 1'b1;
					end
					ktt_pkg::FUNC_ADD: if (wr_en) begin
						valid_q[free_idx_q] <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
					ktt_pkg::FUNC_DEL: if (len_ok_q && hit_q) valid_q[hit_idx_q] <= 1'b0;
					default: ;
				endcase
			end
			if (out_load) begin
				if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && best_ok_q) begin
					emitted_q <= 1'b1;
					idx_q     <= '0;
					rd_ok_q   <= 1'b0;
					best_ok_q <= 1'b0;
				end else out_valid <= 1'b1;
			end
		end
	end

	// The held-back expired result goes out at the decision of the next pass,
	// so an expiry is staged one pass late and flagged last when the scan runs dry.
	logic [4:0] mlen;
	logic [127:0] rd_mask;
	assign mlen = len_q;
	assign rd_mask = ktt_pkg::key_mask(rd_q.len);
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q   <= func;
			len_q    <= key_len;
			len_ok_q <= (key_len != 5'd0) && (key_len <= 5'(ktt_pkg::KeyBytes));
			key_q    <= {key_high, key_low} & ktt_pkg::key_mask(
				((key_len != 5'd0) && (key_len <= 5'(ktt_pkg::KeyBytes)))
				? key_len : 5'(ktt_pkg::KeyBytes));
			port_q   <= port_tag;
			value_q  <= user_value;
			delay_q  <= delay_ms;
		end
		if (out_load) begin
			port_q <= '0;
			value_q <= '0;
			unique case (ktt_pkg::func_t'(func_q))
				ktt_pkg::FUNC_TICK: begin
					kind         <= ktt_pkg::KIND_EXPIRED;
					out_key_low  <= rd_q.key[63:0] & rd_mask[63:0];
					out_key_high <= rd_q.key[127:64] & rd_mask[127:64];
					out_key_len  <= rd_q.len;
					out_port     <= rd_q.port;
					out_value    <= rd_q.value;
					last         <= 1'b0;
				end
				default: begin
					out_key_low  <= key_q[63:0];
					out_key_high <= key_q[127:64];
					out_key_len  <= len_ok_q ? mlen : 5'd0;
					out_port     <= '0;
					out_value    <= '0;
					last         <= 1'b1;
					if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_ADD)
						kind <= !len_ok_q ? ktt_pkg::KIND_BADLEN : hit_q ? ktt_pkg::KIND_DUP :
							!free_ok_q ? ktt_pkg::KIND_FULL : ktt_pkg::KIND_ADDED;
					else
						kind <= (len_ok_q && hit_q) ? ktt_pkg::KIND_DELETED :
							ktt_pkg::KIND_NOTFOUND;
				end
			endcase
			if (ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && !best_ok_q) begin
				kind         <= ktt_pkg::KIND_TICKNONE;
				out_key_low  <= '0;
				out_key_high <= '0;
				out_key_len  <= '0;
				out_port     <= '0;
				out_value    <= '0;
				last         <= 1'b1;
			end
		end
		if (state_q == ktt_pkg::ST_DECIDE && !out_valid &&
			ktt_pkg::func_t'(func_q) == ktt_pkg::FUNC_TICK && !best_ok_q && emitted_q)
			last <= 1'b1;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !out_valid) else $error("input taken while a result waits");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ktt_pkg::ST_SCAN) |-> !in_ready) else $error("ready during scan");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("add did not set one valid bit");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	localparam int WatchdogLimit = 40000;

	typedef struct {
		logic [1:0]  func;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [4:0]  key_len;
		logic [15:0] port_tag;
		logic [31:0] user_value;
		logic [30:0] delay_ms;
	} request_t;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [4:0]  key_len;
		logic [15:0] port;
		logic [31:0] value;
		logic        last;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] func = 0;
	logic [63:0] key_low = 0, key_high = 0;
	logic [4:0] key_len = 0;
	logic [15:0] port_tag = 0;
	logic [31:0] user_value = 0;
	logic [30:0] delay_ms = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] kind;
	logic [63:0] out_key_low, out_key_high;
	logic [4:0] out_key_len;
	logic [15:0] out_port;
	logic [31:0] out_value;
	logic last;

	keyed_timeout_table_top dut (.*);

	always #2 clk = ~clk;

	// Predictor state: a copy of the timeout table.
	logic [39:0]  now_ms;
	logic [31:0]  add_count;
	logic         slot_used [ktt_pkg::Timers];
	logic [127:0] slot_key [ktt_pkg::Timers];
	logic [4:0]   slot_len [ktt_pkg::Timers];
	logic [15:0]  slot_port [ktt_pkg::Timers];
	logic [31:0]  slot_value [ktt_pkg::Timers];
	logic [39:0]  slot_deadline [ktt_pkg::Timers];
	logic [31:0]  slot_order [ktt_pkg::Timers];

	request_t pending_requests[$];
	reply_t   expected_replies[$];
	int mismatches = 0;
	int watchdog = 0;
	int burst_left = 0, gap_left = 0;
	int stall_phase = 0;
	logic [127:0] key_pool [32];
	logic [4:0]   len_pool [32];

	function automatic reply_t make_reply(logic [2:0] k, logic [127:0] key, logic [4:0] len,
			logic [15:0] port, logic [31:0] value);
		reply_t r;
		r.kind = k; r.key_low = key[63:0]; r.key_high = key[127:64];
		r.key_len = len; r.port = port; r.value = value; r.last = 1'b1;
		return r;
	endfunction

	function automatic logic [127:0] byte_mask(int len);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 16; b++)
			if (b < len) m[b*8 +: 8] = 8'hff;
		return m;
	endfunction

	function automatic int find_slot(logic [127:0] key, logic [4:0] len);
		for (int i = 0; i < ktt_pkg::Timers; i++)
			if (slot_used[i] && slot_len[i] == len && slot_key[i] == key) return i;
		return -1;
	endfunction

	task automatic predict_timeouts(request_t rq);
		bit len_ok;
		logic [127:0] key;
		int slot, best, n;
		logic [39:0] age_i, age_b;
		reply_t r;
		len_ok = rq.key_len >= 1 && rq.key_len <= 16;
		key = {rq.key_high, rq.key_low} & byte_mask(len_ok ? int'(rq.key_len) : 16);
		case (rq.func)
			ktt_pkg::FUNC_TICK: begin
				n = 0;
				forever begin
					best = -1;
					for (int i = 0; i < ktt_pkg::Timers; i++) begin
						if (!slot_used[i]) continue;
						age_i = now_ms - slot_deadline[i];
						if (age_i[39]) continue;
						if (best < 0) best = i;
						else begin
							age_b = now_ms - slot_deadline[best];
							if (age_i > age_b) best = i;
							else if (age_i == age_b &&
									((slot_order[best] - slot_order[i]) & 32'h8000_0000) == 0)
								best = i;
						end
					end
					if (best < 0) break;
					slot_used[best] = 0;
					r = make_reply(ktt_pkg::KIND_EXPIRED, slot_key[best], slot_len[best],
						slot_port[best], slot_value[best]);
					r.last = 1'b0;
					expected_replies.push_back(r);
					n++;
				end
				if (n == 0)
					expected_replies.push_back(make_reply(ktt_pkg::KIND_TICKNONE,
						'0, '0, '0, '0));
				else expected_replies[$].last = 1'b1;
				now_ms = now_ms + 40'd1;
			end
			ktt_pkg::FUNC_ADD: begin
				if (!len_ok) begin
					expected_replies.push_back(make_reply(ktt_pkg::KIND_BADLEN, key,
						'0, '0, '0));
				end else if (find_slot(key, rq.key_len) >= 0) begin
					expected_replies.push_back(make_reply(ktt_pkg::KIND_DUP, key, rq.key_len,
						'0, '0));
				end else begin
					slot = -1;
					for (int i = ktt_pkg::Timers - 1; i >= 0; i--)
						if (!slot_used[i]) slot = i;
					if (slot < 0) begin
						expected_replies.push_back(make_reply(ktt_pkg::KIND_FULL, key,
							rq.key_len, '0, '0));
					end else begin
						slot_used[slot] = 1;
						slot_key[slot] = key;
						slot_len[slot] = rq.key_len;
						slot_port[slot] = rq.port_tag;
						slot_value[slot] = rq.user_value;
						slot_deadline[slot] = now_ms + {9'd0, rq.delay_ms};
						slot_order[slot] = add_count;
						add_count = add_count + 32'd1;
						expected_replies.push_back(make_reply(ktt_pkg::KIND_ADDED, key,
							rq.key_len, '0, '0));
					end
				end
			end
			ktt_pkg::FUNC_DEL: begin
				slot = len_ok ? find_slot(key, rq.key_len) : -1;
				if (slot < 0) begin
					expected_replies.push_back(make_reply(ktt_pkg::KIND_NOTFOUND, key,
						len_ok ? rq.key_len : 5'd0, '0, '0));
				end else begin
					slot_used[slot] = 0;
					expected_replies.push_back(make_reply(ktt_pkg::KIND_DELETED, key,
						rq.key_len, '0, '0));
				end
			end
			default: ;
		endcase
	endtask

	function automatic request_t make_request(logic [1:0] f, logic [127:0] key, logic [4:0] len,
			logic [30:0] delay);
		request_t rq;
		rq.func = f; rq.key_low = key[63:0]; rq.key_high = key[127:64]; rq.key_len = len;
		rq.port_tag = 16'($urandom); rq.user_value = $urandom; rq.delay_ms = delay;
		return rq;
	endfunction

	// Driver: bursts of transfers separated by random gaps.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_timeouts('{func, key_low, key_high, key_len, port_tag, user_value, delay_ms});
		end
		if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 0;
			end else if (arst_n && pending_requests.size() > 0) begin
				request_t rq;
				rq = pending_requests.pop_front();
				in_valid <= 1;
				func <= rq.func; key_low <= rq.key_low; key_high <= rq.key_high;
				key_len <= rq.key_len; port_tag <= rq.port_tag;
				user_value <= rq.user_value; delay_ms <= rq.delay_ms;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 6);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver stall pattern and result checks.
	always @(posedge clk) begin
		reply_t e;
		if (out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kind %0d", kind);
			end else begin
				e = expected_replies.pop_front();
				if (kind !== e.kind || out_key_low !== e.key_low || out_key_high !== e.key_high
						|| out_key_len !== e.key_len || out_port !== e.port
						|| out_value !== e.value || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp kind %0d key %h_%h len %0d port %h val %h ",
							"last %0d, got kind %0d key %h_%h len %0d port %h val %h last %0d"},
							e.kind, e.key_high, e.key_low, e.key_len, e.port, e.value, e.last,
							kind, out_key_high, out_key_low, out_key_len, out_port, out_value,
							last);
				end
			end
		end
		stall_phase <= (stall_phase + 1) % 97;
		if (stall_phase < 30) out_ready <= 1;
		else if (stall_phase < 60) out_ready <= (stall_phase % 7) != 3;
		else out_ready <= $urandom_range(0, 3) != 0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WatchdogLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [127:0] k;
		int sel;
		now_ms = 0; add_count = 0;
		for (int i = 0; i < ktt_pkg::Timers; i++) slot_used[i] = 0;
		for (int i = 0; i < 32; i++) begin
			len_pool[i] = 5'($urandom_range(1, 16));
			key_pool[i] = {$urandom, $urandom, $urandom, $urandom};
		end
		// Directed part: extremes, every operation, bad lengths, unused code.
		k = {128{1'b1}};
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd16, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd16, 31'd5));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd8, 31'h7fffffff));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd1, 31'd1));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, '0, 5'd4, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd0, 31'd3));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd17, 31'd3));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k, 5'd31, 31'd3));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_DEL, k, 5'd31, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_DEL, k, 5'd0, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_DEL, k, 5'd9, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_DEL, k, 5'd8, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_NONE, k, 5'd3, 31'd2));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, k, 5'd31, 31'h7fffffff));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		// Fill the table to force the full case, then drain with ticks.
		for (int i = 0; i < ktt_pkg::Timers + 1; i++)
			pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, 128'(i + 1000), 5'd2,
				31'(i % 3)));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		// Random part: keys from a small pool so duplicates and deletes hit.
		for (int n = 0; n < 38; n++) begin
			sel = $urandom_range(0, 31);
			k = key_pool[sel];
			case ($urandom_range(0, 9))
				0, 1, 2:    pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, k,
					'0, '0));
				3, 4, 5, 6: pending_requests.push_back(make_request(ktt_pkg::FUNC_ADD, k,
					len_pool[sel],
					($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6))));
				7, 8:       pending_requests.push_back(make_request(ktt_pkg::FUNC_DEL, k,
					len_pool[sel], '0));
				default:    pending_requests.push_back(make_request(2'($urandom),
					{$urandom, $urandom, $urandom, $urandom}, 5'($urandom), 31'($urandom)));
			endcase
		end
		for (int n = 0; n < 8; n++)
			pending_requests.push_back(make_request(ktt_pkg::FUNC_TICK, '0, '0, '0));
		repeat (5) @(posedge clk);
		arst_n <= 1;
		wait (pending_requests.size() == 0);
		@(posedge clk);
		while (in_valid || expected_replies.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
